// ===== sv/pitc_pkg.sv =====
`default_nettype none

package pitc_pkg;

    // Point coordinate width (signed Q8.8 at the default of 16).
    localparam int COORD_WIDTH = 16;

    // Fixed field widths of the configuration registers.
    localparam int CTR_W      = 16;
    localparam int AX_W       = 16;
    localparam int AX_FRAC    = 14;
    localparam int R_W        = 15;
    localparam int CFG_DATA_W = 3 * AX_W;
    localparam int CFG_ADDR_W = 3;

    // Datapath widths.
    localparam int D_W    = ((COORD_WIDTH > CTR_W) ? COORD_WIDTH : CTR_W) + 1;
    localparam int P_W    = D_W + AX_W;
    localparam int L_W    = P_W + 2;
    localparam int S_W    = 32;
    localparam int SQ_W   = 61;
    localparam int DIST_W = SQ_W + 2;
    localparam int T_W    = R_W + AX_FRAC + 1;
    localparam int TP_W   = (R_W + 1) + (T_W + 1);
    localparam int BASE_W = 2 * R_W;
    localparam int NUM_SHIFT = AX_FRAC + 1;
    localparam int NUM_W  = BASE_W + NUM_SHIFT + 1;
    localparam int Q_W    = R_W + AX_FRAC;
    localparam int DEN_W  = R_W + 1;
    localparam int RR_W   = 2 * Q_W;

    // Distance components saturate at 256.0 in Q.22.
    localparam longint DIST_SAT = 64'sd1 <<< 30;

    // Stream widths.
    localparam int S_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER    = 3'd0,
        REG_X_AXIS    = 3'd1,
        REG_Y_AXIS    = 3'd2,
        REG_Z_AXIS    = 3'd3,
        REG_HALF_H    = 3'd4,
        REG_TOP_R     = 3'd5,
        REG_BOTTOM_R  = 3'd6
    } cfg_reg_t;

    // Pipeline control handed to the divider.
    typedef struct packed {
        logic en;
        logic valid;
    } div_ctl_t;

    // Data that rides along the divider with each word.
    typedef struct packed {
        logic              sphere;
        logic [DIST_W-1:0] dist2;
    } div_side_t;

endpackage

`default_nettype wire

// ===== sv/point_in_tapered_capsule_core.sv =====
`default_nettype none

// Tapered capsule point test. Each input word carries one world-space point
// (x, y, z, signed Q8.8); each output word carries one flag, set when the
// point lies inside or on a capsule whose center, local axes, half height
// and top and bottom radii come from the write port. A half height of zero
// turns the capsule into a sphere of top_radius. The datapath is fully
// pipelined: one word per clock is accepted unless the output stalls, and
// each word passes six arithmetic stages, 29 divider stages that
// resolve one quotient bit each for the interpolated radius, one squaring
// stage and one output register. A stalled output holds the whole pipeline
// only when its last stage holds a word; until then the pipeline keeps
// taking input. Write configuration only while no word is in flight.
module point_in_tapered_capsule_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slave side: tdata = point_x, point_y, point_z (lowest first)
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pitc_pkg::S_TDATA_W-1:0]      s_tdata,
    // master side: tdata = inside_res in bit 0, zeros above
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pitc_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [pitc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pitc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW     = pitc_pkg::COORD_WIDTH;
    localparam int D_W    = pitc_pkg::D_W;
    localparam int P_W    = pitc_pkg::P_W;
    localparam int L_W    = pitc_pkg::L_W;
    localparam int S_W    = pitc_pkg::S_W;
    localparam int SQ_W   = pitc_pkg::SQ_W;
    localparam int DIST_W = pitc_pkg::DIST_W;
    localparam int T_W    = pitc_pkg::T_W;
    localparam int TP_W   = pitc_pkg::TP_W;
    localparam int R_W    = pitc_pkg::R_W;
    localparam int AX_W   = pitc_pkg::AX_W;
    localparam int FRAC   = pitc_pkg::AX_FRAC;
    localparam int BASE_W = pitc_pkg::BASE_W;
    localparam int NUM_W  = pitc_pkg::NUM_W;
    localparam int NSH    = pitc_pkg::NUM_SHIFT;
    localparam int Q_W    = pitc_pkg::Q_W;
    localparam int RR_W   = pitc_pkg::RR_W;
    localparam int CTR_W  = pitc_pkg::CTR_W;

    localparam logic signed [L_W:0] SAT_POS = (L_W+1)'(pitc_pkg::DIST_SAT);
    localparam logic signed [L_W:0] SAT_NEG = -SAT_POS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pitc_pkg::CFG_DATA_W-1:0] center_reg;
    logic [pitc_pkg::CFG_DATA_W-1:0] axis_reg [3];
    logic [R_W-1:0]                  half_h_reg;
    logic [R_W-1:0]                  top_r_reg;
    logic [R_W-1:0]                  bot_r_reg;
    logic [BASE_W-1:0]               base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg  <= '0;
            axis_reg[0] <= pitc_pkg::CFG_DATA_W'(48'h0000_0000_4000);
            axis_reg[1] <= pitc_pkg::CFG_DATA_W'(48'h0000_4000_0000);
            axis_reg[2] <= pitc_pkg::CFG_DATA_W'(48'h4000_0000_0000);
            half_h_reg  <= R_W'(128);
            top_r_reg   <= R_W'(128);
            bot_r_reg   <= R_W'(128);
        end else if (cfg_we) begin
            unique case (pitc_pkg::cfg_reg_t'(cfg_addr))
                pitc_pkg::REG_CENTER:   center_reg  <= cfg_wdata;
                pitc_pkg::REG_X_AXIS:   axis_reg[0] <= cfg_wdata;
                pitc_pkg::REG_Y_AXIS:   axis_reg[1] <= cfg_wdata;
                pitc_pkg::REG_Z_AXIS:   axis_reg[2] <= cfg_wdata;
                pitc_pkg::REG_HALF_H:   half_h_reg  <= cfg_wdata[R_W-1:0];
                pitc_pkg::REG_TOP_R:    top_r_reg   <= cfg_wdata[R_W-1:0];
                pitc_pkg::REG_BOTTOM_R: bot_r_reg   <= cfg_wdata[R_W-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Bottom radius times half height: the constant part of the radius
    // numerator. Registered, so it follows a configuration write in the next cycle.
    always_ff @(posedge aclk) begin
        base_reg <= bot_r_reg * half_h_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic pipe_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic m_tvalid_reg;
    logic inside_res_reg;
    logic div_valid;

    // Hold everything only when a result waits and the last stage is full.
    assign pipe_en  = !(m_tvalid_reg && !m_tready && v7_reg);
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= div_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: subtract the center
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] d_next [3];
    logic signed [D_W-1:0] d_reg  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_next[k] = $signed({{(D_W-CW){s_tdata[k*CW + CW-1]}}, s_tdata[k*CW +: CW]})
                      - $signed({{(D_W-CTR_W){center_reg[k*CTR_W + CTR_W-1]}},
                                 center_reg[k*CTR_W +: CTR_W]});
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: nine axis products
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] prod_reg [3][3];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[a][k] <= P_W'(d_reg[k] * $signed(axis_reg[a][k*AX_W +: AX_W]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: local coordinates (Q.22)
    // ------------------------------------------------------------------
    logic signed [L_W-1:0] l_reg [3];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 3; a++) begin
                l_reg[a] <= L_W'(prod_reg[a][0]) + L_W'(prod_reg[a][1])
                          + L_W'(prod_reg[a][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp y to the segment, form the axis offset, saturate
    // ------------------------------------------------------------------
    function automatic logic signed [S_W-1:0] sat_dist(input logic signed [L_W:0] v);
        logic signed [L_W:0] c;
        c = (v > SAT_POS) ? SAT_POS : ((v < SAT_NEG) ? SAT_NEG : v);
        return c[S_W-1:0];
    endfunction

    logic signed [L_W-1:0] big_h;
    logic signed [L_W-1:0] y_clamp;
    logic signed [L_W:0]   y_off;
    logic signed [L_W-1:0] t_full;
    logic signed [S_W-1:0] sat_reg [3];
    logic [T_W-1:0]        t_reg;

    always_comb begin
        big_h   = $signed(L_W'({half_h_reg, FRAC'(0)}));
        // a zero half height clamps y to zero by itself
        if (l_reg[1] < -big_h) begin
            y_clamp = -big_h;
        end else if (l_reg[1] > big_h) begin
            y_clamp = big_h;
        end else begin
            y_clamp = l_reg[1];
        end
        y_off  = (L_W+1)'(l_reg[1]) - (L_W+1)'(y_clamp);
        t_full = y_clamp + big_h;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sat_reg[0] <= sat_dist((L_W+1)'(l_reg[0]));
            sat_reg[1] <= sat_dist(y_off);
            sat_reg[2] <= sat_dist((L_W+1)'(l_reg[2]));
            t_reg      <= t_full[T_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: squares and the sloped part of the radius numerator
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]        sq_reg [3];
    logic signed [TP_W-1:0] tp_reg;
    logic signed [R_W:0]    r_diff;
    logic signed [2*S_W-1:0] sq_full [3];

    always_comb begin
        r_diff = $signed({1'b0, top_r_reg}) - $signed({1'b0, bot_r_reg});
        for (int k = 0; k < 3; k++) begin
            sq_full[k] = sat_reg[k] * sat_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= sq_full[k][SQ_W-1:0];
            end
            tp_reg <= r_diff * $signed({1'b0, t_reg});
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: distance squared and radius numerator
    // ------------------------------------------------------------------
    logic [DIST_W-1:0]      dist_reg;
    logic [NUM_W-1:0]       num_reg;
    logic                   sphere_reg;
    logic signed [TP_W:0]   num_full;

    // numerator stays non-negative: it blends two non-negative radii
    assign num_full = $signed((TP_W+1)'({base_reg, NSH'(0)})) + (TP_W+1)'(tp_reg);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dist_reg   <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
            num_reg    <= num_full[NUM_W-1:0];
            sphere_reg <= (half_h_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Divider: radius = numerator / (2 * half height), one bit a stage
    // ------------------------------------------------------------------
    pitc_pkg::div_ctl_t  div_ctl;
    pitc_pkg::div_side_t div_side_in;
    pitc_pkg::div_side_t div_side_out;
    logic [Q_W-1:0]      div_quot;

    assign div_ctl.en           = pipe_en;
    assign div_ctl.valid        = v6_reg;
    assign div_side_in.sphere   = sphere_reg;
    assign div_side_in.dist2    = dist_reg;

    pitc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .num       (num_reg),
        .den       ({half_h_reg, 1'b0}),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quot      (div_quot),
        .side_out  (div_side_out)
    );

    // ------------------------------------------------------------------
    // Stage 7: pick the radius and square it
    // ------------------------------------------------------------------
    logic [Q_W-1:0]    radius;
    logic [RR_W-1:0]   rr_reg;
    logic [DIST_W-1:0] dist_f_reg;

    // sphere: radius is the top radius, no interpolation
    assign radius = div_side_out.sphere ? {top_r_reg, FRAC'(0)} : div_quot;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rr_reg     <= radius * radius;
            dist_f_reg <= div_side_out.dist2;
        end
    end

    // ------------------------------------------------------------------
    // Output register: compare, the boundary counts as inside
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en && v7_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && v7_reg) begin
            inside_res_reg <= (dist_f_reg <= DIST_W'(rr_reg));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(pitc_pkg::M_TDATA_W-1)'(0), inside_res_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready && v7_reg))
        else $error("input stalled without a blocked result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && v7_reg) |-> (!m_tvalid_reg || m_tready))
        else $error("new result loaded over an untaken one");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(pipe_en && v7_reg))
        else $error("result appeared without a word in the last stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> m_tvalid_reg)
        else $error("blocked result vanished");

endmodule

`default_nettype wire

// ===== sv/pitc_div.sv =====
`default_nettype none

module pitc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pitc_pkg::div_ctl_t             ctl,
    input  logic [pitc_pkg::NUM_W-1:0]     num,
    input  logic [pitc_pkg::DEN_W-1:0]     den,
    input  pitc_pkg::div_side_t            side_in,
    output logic                           out_valid,
    output logic [pitc_pkg::Q_W-1:0]       quot,
    output pitc_pkg::div_side_t            side_out
);

    localparam int QW = pitc_pkg::Q_W;
    localparam int DW = pitc_pkg::DEN_W;

    logic                v_reg    [QW];
    logic [DW-1:0]       rem_reg  [QW];
    logic [QW-1:0]       low_reg  [QW];
    logic [QW-1:0]       q_reg    [QW];
    logic [DW-1:0]       den_reg  [QW];
    pitc_pkg::div_side_t side_reg [QW];

    logic                src_v    [QW];
    logic [DW-1:0]       src_rem  [QW];
    logic [QW-1:0]       src_low  [QW];
    logic [QW-1:0]       src_q    [QW];
    logic [DW-1:0]       src_den  [QW];
    pitc_pkg::div_side_t src_side [QW];

    logic [DW:0]         trial    [QW];
    logic                ge       [QW];
    logic [DW-1:0]       rem_next [QW];

    // One quotient bit per stage: shift in the next numerator bit, subtract if it fits.
    always_comb begin
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                src_v[j]    = ctl.valid;
                src_rem[j]  = num[QW +: DW];
                src_low[j]  = num[QW-1:0];
                src_q[j]    = '0;
                src_den[j]  = den;
                src_side[j] = side_in;
            end else begin
                src_v[j]    = v_reg[j-1];
                src_rem[j]  = rem_reg[j-1];
                src_low[j]  = low_reg[j-1];
                src_q[j]    = q_reg[j-1];
                src_den[j]  = den_reg[j-1];
                src_side[j] = side_reg[j-1];
            end
            trial[j]    = {src_rem[j], src_low[j][QW-1]};
            ge[j]       = (trial[j] >= {1'b0, src_den[j]});
            rem_next[j] = ge[j] ? DW'(trial[j] - {1'b0, src_den[j]}) : DW'(trial[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < QW; j++) begin
                v_reg[j] <= 1'b0;
            end
        end else if (ctl.en) begin
            for (int j = 0; j < QW; j++) begin
                v_reg[j] <= src_v[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int j = 0; j < QW; j++) begin
                rem_reg[j]  <= rem_next[j];
                low_reg[j]  <= {src_low[j][QW-2:0], 1'b0};
                q_reg[j]    <= {src_q[j][QW-2:0], ge[j]};
                den_reg[j]  <= src_den[j];
                side_reg[j] <= src_side[j];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire
